@@ hdl/crs_pkg.sv @@
// Shared types, constants and reply text tables for the cover relay sequencer.
package crs_pkg;

   // Longest command line that is still counted; further bytes are dropped.
   localparam int LINE_LIMIT  = 16;
   localparam int LINE_LEN_W  = $clog2(LINE_LIMIT + 1);
   localparam int CSR_INDEX_W = 8;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_SINGLE_TICKS = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_TICKS = CSR_INDEX_W'(1);

   localparam logic [7:0] SINGLE_TICKS_RESET = 8'd5;
   localparam logic [7:0] ACTIVE_TICKS_RESET = 8'd27;

   // Input operations.
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Result kinds.
   localparam logic KIND_TEXT  = 1'b0;
   localparam logic KIND_RELAY = 1'b1;

   // Characters of interest.
   localparam logic [7:0] CHR_CR    = 8'h0D;
   localparam logic [7:0] CHR_LF    = 8'h0A;
   localparam logic [7:0] CHR_QUERY = 8'h3F;
   localparam logic [7:0] CHR_OPEN  = 8'h4F;
   localparam logic [7:0] CHR_CLOSE = 8'h43;
   localparam logic [7:0] CHR_STOP  = 8'h53;

   // Cover states.
   typedef enum logic [1:0] {
      ST_STOPPED = 2'd0,
      ST_OPEN    = 2'd1,
      ST_CLOSED  = 2'd2
   } cover_state_type;

   // Relay drive patterns.
   localparam logic [3:0] DRV_IDLE       = 4'b0000;
   localparam logic [3:0] DRV_OPEN_ONE   = 4'b1001;
   localparam logic [3:0] DRV_OPEN_BOTH  = 4'b1101;
   localparam logic [3:0] DRV_CLOSE_ONE  = 4'b0110;
   localparam logic [3:0] DRV_CLOSE_BOTH = 4'b1110;

   // Reply messages; a relay update counts as a one-beat message.
   typedef enum logic [2:0] {
      MSG_UNKNOWN = 3'd0,
      MSG_ACK     = 3'd1,
      MSG_STOPPED = 3'd2,
      MSG_OPEN    = 3'd3,
      MSG_CLOSED  = 3'd4,
      MSG_OPENING = 3'd5,
      MSG_CLOSING = 3'd6,
      MSG_TICK    = 3'd7
   } msg_type;

   typedef struct packed {
      logic       operation;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] text_char;
      logic [3:0] relays;
      logic       last;
   } rsp_type;

   // One pending reply, handed from the command logic to the serialiser.
   typedef struct packed {
      msg_type    msg;
      logic [3:0] relays;
   } job_type;

   typedef logic [7:0][7:0] text_type;

   // Message text, first character in element 0.
   function automatic text_type msg_text(msg_type m);
      text_type t;
      t = '0;
      case (m)
         MSG_UNKNOWN: t = {48'h0, CHR_CR, CHR_QUERY};
         MSG_ACK:     t = {48'h0, CHR_CR, 8'h24};
         MSG_STOPPED: t = {CHR_CR, "DEPPOTS"};
         MSG_OPEN:    t = {24'h0, CHR_CR, "NEPO"};
         MSG_CLOSED:  t = {8'h0, CHR_CR, "DESOLC"};
         MSG_OPENING: t = {CHR_CR, "GNINEPO"};
         MSG_CLOSING: t = {CHR_CR, "GNISOLC"};
         default:     t = '0;
      endcase
      return t;
   endfunction

   // Position of the final beat of a message.
   function automatic logic [2:0] msg_last_pos(msg_type m);
      logic [2:0] p;
      p = 3'd0;
      case (m)
         MSG_UNKNOWN: p = 3'd1;
         MSG_ACK:     p = 3'd1;
         MSG_STOPPED: p = 3'd7;
         MSG_OPEN:    p = 3'd4;
         MSG_CLOSED:  p = 3'd6;
         MSG_OPENING: p = 3'd7;
         MSG_CLOSING: p = 3'd7;
         default:     p = 3'd0;
      endcase
      return p;
   endfunction

endpackage

@@ hdl/crs_cmd_ctrl.sv @@
// Command line parser, tick sequencer and configuration registers.
module crs_cmd_ctrl import crs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  req_type                req_data,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata,
   output logic                   job_valid,
   output job_type                job
);

   logic [7:0]            single_ticks_ff, single_ticks_in;
   logic [7:0]            active_ticks_ff, active_ticks_in;
   cover_state_type       target_ff, target_in;
   cover_state_type       settled_ff, settled_in;
   logic [7:0]            move_ff, move_in;
   logic [3:0]            drive_ff, drive_in;
   logic [LINE_LEN_W-1:0] line_len_ff, line_len_in;
   logic [7:0]            first_char_ff, first_char_in;

   logic       line_end;
   logic [2:0] status_idx;
   msg_type    status_msg;

   // Status label index: settled state, plus two while a movement runs.
   always_comb begin
      status_idx = {1'b0, settled_ff} + ((move_ff != 8'd0) ? 3'd2 : 3'd0);
      case (status_idx)
         3'd1:    status_msg = MSG_OPEN;
         3'd2:    status_msg = MSG_CLOSED;
         3'd3:    status_msg = MSG_OPENING;
         3'd4:    status_msg = MSG_CLOSING;
         default: status_msg = MSG_STOPPED;
      endcase
   end

   assign line_end = (line_len_ff != '0) &&
                     ((req_data.rx_byte == CHR_CR) || (req_data.rx_byte == CHR_LF));

   always_comb begin
      single_ticks_in = single_ticks_ff;
      active_ticks_in = active_ticks_ff;
      target_in       = target_ff;
      settled_in      = settled_ff;
      move_in         = move_ff;
      drive_in        = drive_ff;
      line_len_in     = line_len_ff;
      first_char_in   = first_char_ff;
      job_valid       = 1'b0;
      job.msg         = MSG_TICK;
      job.relays      = drive_ff;

      if (csr_write) begin
         if (csr_index == CSR_SINGLE_TICKS) begin
            single_ticks_in = csr_wdata;
         end else if (csr_index == CSR_ACTIVE_TICKS) begin
            active_ticks_in = csr_wdata;
         end
      end

      if (accept) begin
         if (req_data.operation == OP_TICK) begin
            if (move_ff == single_ticks_ff) begin
               drive_in = (target_ff == ST_OPEN) ? DRV_OPEN_BOTH : DRV_CLOSE_BOTH;
            end
            if (move_ff == active_ticks_ff) begin
               drive_in = DRV_IDLE;
               move_in  = 8'd0;
            end
            if (move_in != 8'd0) begin
               move_in = move_in + 8'd1;
            end
            if (target_ff != settled_ff) begin
               if (target_ff != ST_STOPPED) begin
                  drive_in = (target_ff == ST_OPEN) ? DRV_OPEN_ONE : DRV_CLOSE_ONE;
                  move_in  = 8'd1;
               end else begin
                  drive_in = DRV_IDLE;
                  move_in  = 8'd0;
               end
               settled_in = target_ff;
            end
            job_valid  = 1'b1;
            job.msg    = MSG_TICK;
            job.relays = drive_in;
         end else if (line_end) begin
            job.msg = MSG_UNKNOWN;
            if (line_len_ff == LINE_LEN_W'(1)) begin
               if (first_char_ff == CHR_QUERY) begin
                  job.msg = status_msg;
               end else if (first_char_ff == CHR_CLOSE) begin
                  target_in = ST_CLOSED;
                  job.msg   = MSG_ACK;
               end else if (first_char_ff == CHR_OPEN) begin
                  target_in = ST_OPEN;
                  job.msg   = MSG_ACK;
               end else if (first_char_ff == CHR_STOP) begin
                  target_in = ST_STOPPED;
                  job.msg   = MSG_ACK;
               end
            end
            line_len_in = '0;
            job_valid   = 1'b1;
         end else begin
            if (line_len_ff == '0) begin
               first_char_in = req_data.rx_byte;
            end
            if (line_len_ff < LINE_LEN_W'(LINE_LIMIT)) begin
               line_len_in = line_len_ff + LINE_LEN_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         single_ticks_ff <= SINGLE_TICKS_RESET;
         active_ticks_ff <= ACTIVE_TICKS_RESET;
         target_ff       <= ST_STOPPED;
         settled_ff      <= ST_STOPPED;
         move_ff         <= 8'd0;
         drive_ff        <= DRV_IDLE;
         line_len_ff     <= '0;
         first_char_ff   <= 8'd0;
      end else begin
         single_ticks_ff <= single_ticks_in;
         active_ticks_ff <= active_ticks_in;
         target_ff       <= target_in;
         settled_ff      <= settled_in;
         move_ff         <= move_in;
         drive_ff        <= drive_in;
         line_len_ff     <= line_len_in;
         first_char_ff   <= first_char_in;
      end
   end

endmodule

@@ hdl/crs_reply_ser.sv @@
// Result register that plays a reply out one character per beat.
module crs_reply_ser import crs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   input  job_type job,
   output logic    slot_free,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic       valid_ff, valid_in;
   job_type    job_ff, job_in;
   logic [2:0] pos_ff, pos_in;
   logic       at_last;
   text_type   text;

   assign text    = msg_text(job_ff.msg);
   assign at_last = (pos_ff == msg_last_pos(job_ff.msg));

   assign rsp_valid          = valid_ff;
   assign rsp_data.kind      = (job_ff.msg == MSG_TICK) ? KIND_RELAY : KIND_TEXT;
   assign rsp_data.text_char = text[pos_ff];
   assign rsp_data.relays    = job_ff.relays;
   assign rsp_data.last      = at_last;

   // The slot frees up in the same cycle as the final beat leaves.
   assign slot_free = !valid_ff || (rsp_ready && at_last);

   always_comb begin
      valid_in = valid_ff;
      job_in   = job_ff;
      pos_in   = pos_ff;
      if (job_valid) begin
         valid_in = 1'b1;
         job_in   = job;
         pos_in   = 3'd0;
      end else if (valid_ff && rsp_ready) begin
         if (at_last) begin
            valid_in = 1'b0;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pos_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         pos_ff   <= pos_in;
      end
      job_ff <= job_in;
   end

endmodule

@@ hdl/cover_relay_sequencer_core.sv @@
// Top level of the cover relay sequencer: command parser, tick sequencer and reply serialiser.
//
// The req_ channel carries one beat per input item: either a received command
// byte or a one-second tick. Bytes are gathered into lines ending at CR or LF;
// a completed line produces a reply of two to eight text characters on the
// rsp_ channel, one character per beat, with last set on the final beat. Every
// tick produces exactly one relay update beat carrying the new relay pattern.
// A byte that does not end a line produces no beat at all.
// The reply's first beat is valid in the cycle after the item is accepted.
// Throughput is one item per cycle while each item yields at most one beat
// and the receiver takes every beat; a multi-character reply occupies the
// single result register until its final beat is taken, which sets the rate.
// req_ready is high whenever the result register is empty or its final beat
// is being taken, so a stalled receiver holds off the sender only while the
// current reply is pending. The csr_ channel is always ready and writes the
// single_ticks (index 0) and active_ticks (index 1) registers; other indexes
// are ignored. Synchronous reset returns to the stopped state with idle
// relays, an empty line buffer and the register defaults of 5 and 27 ticks.
module cover_relay_sequencer_core import crs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata
);

   logic    accept;
   logic    job_valid;
   job_type job;
   logic    slot_free;

   // Configuration writes are taken at any time.
   assign csr_ready = 1'b1;
   assign req_ready = slot_free;
   assign accept    = req_valid && req_ready;

   // Parser and sequencer: all state updates for an item happen at acceptance.
   crs_cmd_ctrl u_cmd_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .job_valid (job_valid),
      .job       (job)
   );

   // Result register and character sequencing for multi-beat replies.
   crs_reply_ser u_reply_ser (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // A pending reply that is not being completed must hold off new items.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !(rsp_ready && rsp_data.last)) |-> !req_ready)
      else $error("item accepted while reply still pending");

   // A relay update is always a single, final beat with no text.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == KIND_RELAY) |-> (rsp_data.last && rsp_data.text_char == 8'd0))
      else $error("malformed relay update beat");

   // Only the defined drive patterns ever reach the relays.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.relays == DRV_IDLE || rsp_data.relays == DRV_OPEN_ONE ||
                     rsp_data.relays == DRV_OPEN_BOTH || rsp_data.relays == DRV_CLOSE_ONE ||
                     rsp_data.relays == DRV_CLOSE_BOTH))
      else $error("illegal relay pattern");

   // Nothing is presented in the cycle after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

endmodule
